// File: hdl/dlle_pkg.sv
// Shared types and constants of the doubly linked list engine.
package dlle_pkg;

  localparam int NODES  = 256;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = IDX_W + 1;
  localparam int VAL_W  = 32;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 56;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

  localparam logic [2:0] F_ADD_START  = 3'd0;
  localparam logic [2:0] F_ADD_END    = 3'd1;
  localparam logic [2:0] F_REM_START  = 3'd2;
  localparam logic [2:0] F_REM_END    = 3'd3;
  localparam logic [2:0] F_GET        = 3'd4;
  localparam logic [2:0] F_INS_AFTER  = 3'd5;
  localparam logic [2:0] F_INS_BEFORE = 3'd6;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_HANDLE = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              val_we;
    logic [IDX_W-1:0]  val_waddr;
    logic [VAL_W-1:0]  val_wdata;
    logic              next_we;
    logic [IDX_W-1:0]  next_waddr;
    logic [LINK_W-1:0] next_wdata;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_waddr;
    logic [LINK_W-1:0] prev_wdata;
  } pool_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  val;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } pool_rsp_t;

endpackage

// File: hdl/dlle_node_pool.sv
// Node pool memories holding values and forward and backward links.
module dlle_node_pool import dlle_pkg::*; (
  input  logic      clk,
  input  pool_req_t req,
  output pool_rsp_t rsp
);

  logic [VAL_W-1:0]  node_value_r [NODES];
  logic [LINK_W-1:0] next_link_r  [NODES];
  logic [LINK_W-1:0] prev_link_r  [NODES];
  pool_rsp_t         rsp_r;

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      node_value_r[req.val_waddr] <= req.val_wdata;
    end
    if (req.next_we) begin
      next_link_r[req.next_waddr] <= req.next_wdata;
    end
    if (req.prev_we) begin
      prev_link_r[req.prev_waddr] <= req.prev_wdata;
    end
    rsp_r.val  <= node_value_r[req.rd_addr];
    rsp_r.next <= next_link_r[req.rd_addr];
    rsp_r.prev <= prev_link_r[req.rd_addr];
  end

  assign rsp = rsp_r;

endmodule

// File: hdl/doubly_linked_list_engine_unit.sv
// Top level of the doubly linked list engine with its sequencer and free stack.
// Add and insert allocate a node and then link it, remove unlinks the end node, get walks
// from the head with one node memory read per link step, and errors and no-op go to the result.
// One transaction is handled at a time; the next is accepted in the cycle after the result
// is taken, so an item holds the engine until its result is taken.
// Synchronous active-low reset empties the list and clears all live marks at once;
// there is no clearing pass, and no node memory or free stack word is used before it is written.
module doubly_linked_list_engine_unit import dlle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // func[2:0], value[34:3], position[42:35], node_handle[50:43], zero fill
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status[2:0], result_value[34:3], new_handle[42:35], element_count[51:43], zero fill
  output logic [OUT_W-1:0] out_tdata
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_ALLOC  = 8'b0000_0100,
    S_LINK   = 8'b0000_1000,
    S_REMOVE = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_WSTEP  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t            state_r;
  logic [LINK_W-1:0] head_r;
  logic [LINK_W-1:0] tail_r;
  logic [LINK_W-1:0] count_r;
  logic [LINK_W-1:0] free_top_r;
  logic [LINK_W-1:0] fresh_r;
  logic [NODES-1:0]  live_r;

  logic [2:0]        func_r;
  logic [VAL_W-1:0]  value_r;
  logic [IDX_W-1:0]  position_r;
  logic [IDX_W-1:0]  node_handle_r;
  logic [IDX_W-1:0]  p_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  n_r;
  logic [LINK_W-1:0] q_r;
  logic [2:0]        status_r;
  logic [VAL_W-1:0]  rv_r;
  logic [IDX_W-1:0]  nh_r;

  logic [IDX_W-1:0]  free_stack_r [NODES];
  logic [IDX_W-1:0]  fs_rd_r;
  logic [IDX_W-1:0]  fs_raddr;
  logic              fs_we;

  pool_req_t         req;
  pool_rsp_t         rsp;

  logic              pool_full;
  logic [IDX_W-1:0]  alloc_n;
  logic [IDX_W-1:0]  rm_n;
  logic              is_add;
  logic              is_ins;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {4'd0, count_r, nh_r, rv_r, status_r};

  assign pool_full = (free_top_r == '0) && (fresh_r == NIL);
  assign alloc_n   = (free_top_r != '0) ? fs_rd_r : fresh_r[IDX_W-1:0];
  assign rm_n      = (func_r == F_REM_START) ? head_r[IDX_W-1:0] : tail_r[IDX_W-1:0];
  assign is_add    = (func_r == F_ADD_START) || (func_r == F_ADD_END);
  assign is_ins    = (func_r == F_INS_AFTER) || (func_r == F_INS_BEFORE);
  assign fs_raddr  = IDX_W'(free_top_r - LINK_W'(1));
  assign fs_we     = (state_r == S_REMOVE) && (free_top_r < NIL);

  always_ff @(posedge clk) begin
    if (fs_we) begin
      free_stack_r[free_top_r[IDX_W-1:0]] <= rm_n;
    end
    fs_rd_r <= free_stack_r[fs_raddr];
  end

  always_comb begin
    req = '0;
    case (state_r)
      S_DECODE: begin
        req.rd_addr = is_ins ? node_handle_r : rm_n;
      end
      S_WALK: begin
        req.rd_addr = p_r;
      end
      S_ALLOC: begin
        req.val_we     = 1'b1;
        req.val_waddr  = alloc_n;
        req.val_wdata  = value_r;
        req.next_we    = 1'b1;
        req.next_waddr = alloc_n;
        req.prev_we    = 1'b1;
        req.prev_waddr = alloc_n;
        case (func_r)
          F_ADD_START: begin
            req.prev_wdata = NIL;
            req.next_wdata = head_r;
          end
          F_ADD_END: begin
            req.prev_wdata = tail_r;
            req.next_wdata = NIL;
          end
          F_INS_AFTER: begin
            req.prev_wdata = {1'b0, node_handle_r};
            req.next_wdata = rsp.next;
          end
          default: begin
            req.prev_wdata = rsp.prev;
            req.next_wdata = {1'b0, node_handle_r};
          end
        endcase
      end
      S_LINK: begin
        case (func_r)
          F_ADD_START: begin
            req.prev_we    = (head_r != NIL);
            req.prev_waddr = head_r[IDX_W-1:0];
            req.prev_wdata = {1'b0, n_r};
          end
          F_ADD_END: begin
            req.next_we    = (head_r != NIL);
            req.next_waddr = tail_r[IDX_W-1:0];
            req.next_wdata = {1'b0, n_r};
          end
          F_INS_AFTER: begin
            req.next_we    = 1'b1;
            req.next_waddr = node_handle_r;
            req.next_wdata = {1'b0, n_r};
            req.prev_we    = (q_r != NIL);
            req.prev_waddr = q_r[IDX_W-1:0];
            req.prev_wdata = {1'b0, n_r};
          end
          default: begin
            req.prev_we    = 1'b1;
            req.prev_waddr = node_handle_r;
            req.prev_wdata = {1'b0, n_r};
            req.next_we    = (q_r != NIL);
            req.next_waddr = q_r[IDX_W-1:0];
            req.next_wdata = {1'b0, n_r};
          end
        endcase
      end
      S_REMOVE: begin
        if (head_r != tail_r) begin
          if (func_r == F_REM_START) begin
            req.prev_we    = 1'b1;
            req.prev_waddr = rsp.next[IDX_W-1:0];
            req.prev_wdata = NIL;
          end else begin
            req.next_we    = 1'b1;
            req.next_waddr = rsp.prev[IDX_W-1:0];
            req.next_wdata = NIL;
          end
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  dlle_node_pool u_pool (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= NIL;
      tail_r     <= NIL;
      count_r    <= '0;
      free_top_r <= '0;
      fresh_r    <= '0;
      live_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (is_add) begin
            state_r <= pool_full ? S_DONE : S_ALLOC;
          end else if ((func_r == F_REM_START) || (func_r == F_REM_END)) begin
            state_r <= (head_r == NIL) ? S_DONE : S_REMOVE;
          end else if (func_r == F_GET) begin
            state_r <= ({1'b0, position_r} >= count_r) ? S_DONE : S_WALK;
          end else if (is_ins) begin
            state_r <= (!live_r[node_handle_r] || pool_full) ? S_DONE : S_ALLOC;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_ALLOC: begin
          live_r[alloc_n] <= 1'b1;
          count_r         <= count_r + LINK_W'(1);
          if (free_top_r != '0) begin
            free_top_r <= free_top_r - LINK_W'(1);
          end else begin
            fresh_r <= fresh_r + LINK_W'(1);
          end
          state_r <= S_LINK;
        end
        S_LINK: begin
          case (func_r)
            F_ADD_START: begin
              head_r <= {1'b0, n_r};
              if (head_r == NIL) begin
                tail_r <= {1'b0, n_r};
              end
            end
            F_ADD_END: begin
              tail_r <= {1'b0, n_r};
              if (head_r == NIL) begin
                head_r <= {1'b0, n_r};
              end
            end
            F_INS_AFTER: begin
              if (q_r == NIL) begin
                tail_r <= {1'b0, n_r};
              end
            end
            default: begin
              if (q_r == NIL) begin
                head_r <= {1'b0, n_r};
              end
            end
          endcase
          state_r <= S_DONE;
        end
        S_REMOVE: begin
          if (head_r == tail_r) begin
            head_r <= NIL;
            tail_r <= NIL;
          end else if (func_r == F_REM_START) begin
            head_r <= rsp.next;
          end else begin
            tail_r <= rsp.prev;
          end
          live_r[rm_n] <= 1'b0;
          if (free_top_r < NIL) begin
            free_top_r <= free_top_r + LINK_W'(1);
          end
          count_r <= count_r - LINK_W'(1);
          state_r <= S_DONE;
        end
        S_WALK: begin
          state_r <= S_WSTEP;
        end
        S_WSTEP: begin
          state_r <= (i_r == position_r) ? S_DONE : S_WALK;
        end
        S_DONE: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        func_r        <= in_tdata[2:0];
        value_r       <= in_tdata[34:3];
        position_r    <= in_tdata[42:35];
        node_handle_r <= in_tdata[50:43];
        status_r      <= ST_OK;
        rv_r          <= '0;
        nh_r          <= '0;
      end
      S_DECODE: begin
        p_r <= head_r[IDX_W-1:0];
        i_r <= '0;
        if (is_add) begin
          if (pool_full) begin
            status_r <= ST_FULL;
          end
        end else if ((func_r == F_REM_START) || (func_r == F_REM_END)) begin
          if (head_r == NIL) begin
            status_r <= ST_EMPTY;
          end
        end else if (func_r == F_GET) begin
          if ({1'b0, position_r} >= count_r) begin
            status_r <= ST_RANGE;
          end
        end else if (is_ins) begin
          if (!live_r[node_handle_r]) begin
            status_r <= ST_HANDLE;
          end else if (pool_full) begin
            status_r <= ST_FULL;
          end
        end
      end
      S_ALLOC: begin
        n_r  <= alloc_n;
        nh_r <= alloc_n;
        q_r  <= (func_r == F_INS_AFTER) ? rsp.next : rsp.prev;
      end
      S_REMOVE: begin
        rv_r <= rsp.val;
      end
      S_WSTEP: begin
        if (i_r == position_r) begin
          rv_r <= rsp.val;
        end else begin
          p_r <= rsp.next[IDX_W-1:0];
          i_r <= i_r + IDX_W'(1);
        end
      end
      default: begin
        p_r <= p_r;
      end
    endcase
  end

endmodule
